// File: rtl/core/sqbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sqbs_pkg;

    localparam int MAX_QUADS     = 16384;
    localparam int TEXTURE_SLOTS = 32;
    localparam int NCELL         = TEXTURE_SLOTS - 1;
    localparam int QC_W          = $clog2(MAX_QUADS + 1);
    localparam int SLOT_W        = 5;
    localparam int USED_W        = 6;
    localparam int PROD_W        = 50;

    localparam logic [17:0] SIN_A   = 18'd25736;
    localparam logic [17:0] SIN_B   = 18'd10512;
    localparam logic [17:0] SIN_C   = 18'd1160;
    localparam logic [15:0] Q14_ONE = 16'd16384;
    localparam logic [15:0] TILE_ONE = 16'd256;

    localparam logic [1:0] MODE_SOLID = 2'd0;
    localparam logic [1:0] MODE_TEX   = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam logic KIND_VERT  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_FLUSH,
        S_ASSIGN,
        S_MATH,
        S_VERT
    } t_state;

    // Lookup query travelling down the slot chain.
    typedef struct packed {
        logic              valid;
        logic [31:0]       id;
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_query;

    // Slot write broadcast to every cell.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       id;
    } t_write;

endpackage
`default_nettype wire

// File: rtl/core/sprite_quad_batch_setup_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Sprite quad batch setup. Each input transaction is one sprite request
// (solid quad, textured quad, end-of-frame flush or an unused mode that
// is ignored, selected by tuser); a quad yields four vertex transactions,
// preceded by one flush transaction when the batch or the texture slot
// table is full, and an end-of-frame request yields one flush transaction.
// The block takes one request at a time: a textured lookup walks the row
// of 31 slot cells, one cell per cycle, and the sine, cosine and four
// corner products share a single multiplier, one product after another.
// The slot table needs no clearing after reset.
module sprite_quad_batch_setup_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // pos_x, pos_y, pos_z, size_w, size_h, angle, color, tiling, texture_id
    input  wire logic [255:0] s_axis_tdata,
    // mode
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // vert_x, vert_y, vert_z, tex_u, tex_v, slot, vert_color, vert_tiling,
    // batch_quads, slots_used, then four zero bits
    output logic [175:0]      m_axis_tdata,
    // kind
    output logic              m_axis_tuser,
    output logic              m_axis_tlast
);

    localparam int W = sqbs_pkg::PROD_W + 2;

    sqbs_pkg::t_state r_state, n_state;

    // Latched request.
    logic [1:0]         r_mode;
    logic signed [31:0] r_px, r_py, r_w, r_h;
    logic [31:0]        r_pz, r_color, r_tid;
    logic [15:0]        r_angle, r_tiling;

    logic [sqbs_pkg::QC_W-1:0]   r_qc;
    logic [sqbs_pkg::USED_W-1:0] r_used;
    logic [sqbs_pkg::SLOT_W-1:0] r_slot;
    logic                        r_flush;
    logic                        r_new;
    logic                        r_hit;
    logic [sqbs_pkg::SLOT_W-1:0] r_hslot;
    logic [1:0]                  r_k;

    logic         r_mvalid;
    logic [175:0] r_mdata;
    logic         r_muser;
    logic         r_mlast;

    sqbs_pkg::t_query r_qhead;
    sqbs_pkg::t_query chain [0:sqbs_pkg::NCELL];
    sqbs_pkg::t_write wr;

    logic accept, full, out_ld, math_start, math_done;
    logic signed [sqbs_pkg::PROD_W-1:0] wc, hs, ws, hc;
    logic signed [W-1:0] sum_x, sum_y;
    logic [175:0] n_mdata;
    logic         n_muser, n_mlast;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign full   = r_qc >= sqbs_pkg::QC_W'(sqbs_pkg::MAX_QUADS);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sqbs_pkg::S_IDLE: begin
                if (accept) begin
                    if (s_axis_tuser == sqbs_pkg::MODE_NONE) begin
                        n_state = sqbs_pkg::S_IDLE;
                    end else if (s_axis_tuser == sqbs_pkg::MODE_FLUSH) begin
                        n_state = sqbs_pkg::S_FLUSH;
                    end else if (s_axis_tuser == sqbs_pkg::MODE_TEX && !full) begin
                        n_state = sqbs_pkg::S_SEARCH;
                    end else begin
                        n_state = sqbs_pkg::S_DECIDE;
                    end
                end
            end
            sqbs_pkg::S_SEARCH: begin
                if (chain[sqbs_pkg::NCELL].valid) n_state = sqbs_pkg::S_DECIDE;
            end
            sqbs_pkg::S_DECIDE: begin
                n_state = sqbs_pkg::S_ASSIGN;
            end
            sqbs_pkg::S_FLUSH: begin
                if (out_ld) begin
                    n_state = (r_mode == sqbs_pkg::MODE_FLUSH) ? sqbs_pkg::S_IDLE
                                                               : sqbs_pkg::S_ASSIGN;
                end
            end
            sqbs_pkg::S_ASSIGN: begin
                n_state = r_flush ? sqbs_pkg::S_FLUSH : sqbs_pkg::S_MATH;
            end
            sqbs_pkg::S_MATH: begin
                if (math_done) n_state = sqbs_pkg::S_VERT;
            end
            sqbs_pkg::S_VERT: begin
                if (out_ld && r_k == 2'd3) n_state = sqbs_pkg::S_IDLE;
            end
            default: n_state = sqbs_pkg::S_IDLE;
        endcase
    end

    // Control outputs. ASSIGN is visited twice when a flush is pending:
    // first it hands over to FLUSH, then it binds the slot and starts math.
    always_comb begin
        s_axis_tready = (r_state == sqbs_pkg::S_IDLE);
        out_ld = ((r_state == sqbs_pkg::S_FLUSH) || (r_state == sqbs_pkg::S_VERT))
                 && (!r_mvalid || m_axis_tready);
        math_start = (r_state == sqbs_pkg::S_ASSIGN) && !r_flush;
        wr.en   = math_start && r_new;
        wr.slot = r_slot;
        wr.id   = r_tid;
    end

    // Corner signs (-,-), (+,-), (+,+), (-,+).
    always_comb begin
        logic neg_x, neg_y;
        logic signed [W-1:0] ewc, ehs, ews, ehc;
        neg_x = (r_k == 2'd0) || (r_k == 2'd3);
        neg_y = (r_k == 2'd0) || (r_k == 2'd1);
        ewc = W'(wc);
        ehs = W'(hs);
        ews = W'(ws);
        ehc = W'(hc);
        sum_x = (neg_x ? -ewc : ewc) - (neg_y ? -ehs : ehs) + W'(16384);
        sum_y = (neg_x ? -ews : ews) + (neg_y ? -ehc : ehc) + W'(16384);
    end

    always_comb begin
        n_mdata = '0;
        n_muser = sqbs_pkg::KIND_VERT;
        n_mlast = 1'b0;
        if (r_state == sqbs_pkg::S_FLUSH) begin
            n_muser = sqbs_pkg::KIND_FLUSH;
            n_mlast = (r_mode == sqbs_pkg::MODE_FLUSH);
            n_mdata[165:151] = 15'(r_qc);
            n_mdata[171:166] = r_used;
        end else begin
            n_mdata[31:0]    = r_px + sum_x[46:15];
            n_mdata[63:32]   = r_py + sum_y[46:15];
            n_mdata[95:64]   = r_pz;
            n_mdata[96]      = (r_k == 2'd1) || (r_k == 2'd2);
            n_mdata[97]      = r_k[1];
            n_mdata[102:98]  = r_slot;
            n_mdata[134:103] = r_color;
            n_mdata[150:135] = (r_mode == sqbs_pkg::MODE_TEX) ? r_tiling
                                                              : sqbs_pkg::TILE_ONE;
            n_mlast = (r_k == 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= sqbs_pkg::S_IDLE;
            r_qc          <= '0;
            r_used        <= sqbs_pkg::USED_W'(1);
            r_mvalid      <= 1'b0;
            r_qhead.valid <= 1'b0;
            r_flush       <= 1'b0;
            r_k           <= '0;
        end else begin
            r_state <= n_state;
            r_qhead.valid <= accept && (s_axis_tuser == sqbs_pkg::MODE_TEX) && !full;
            if (out_ld) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
            if (r_state == sqbs_pkg::S_IDLE) r_k <= '0;
            if (r_state == sqbs_pkg::S_DECIDE) begin
                if (r_mode == sqbs_pkg::MODE_TEX && !full && !r_hit) begin
                    r_flush <= r_used >= sqbs_pkg::USED_W'(sqbs_pkg::TEXTURE_SLOTS);
                end else begin
                    r_flush <= full;
                end
            end
            if (r_state == sqbs_pkg::S_FLUSH && out_ld) begin
                r_qc    <= '0;
                r_used  <= sqbs_pkg::USED_W'(1);
                r_flush <= 1'b0;
            end
            if (wr.en) r_used <= sqbs_pkg::USED_W'(r_slot) + sqbs_pkg::USED_W'(1);
            if (r_state == sqbs_pkg::S_VERT && out_ld) begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd3) r_qc <= r_qc + sqbs_pkg::QC_W'(1);
            end
        end
        if (accept) begin
            r_mode   <= s_axis_tuser;
            r_px     <= s_axis_tdata[31:0];
            r_py     <= s_axis_tdata[63:32];
            r_pz     <= s_axis_tdata[95:64];
            r_w      <= s_axis_tdata[127:96];
            r_h      <= s_axis_tdata[159:128];
            r_angle  <= s_axis_tdata[175:160];
            r_color  <= s_axis_tdata[207:176];
            r_tiling <= s_axis_tdata[223:208];
            r_tid    <= s_axis_tdata[255:224];
            r_hit    <= 1'b0;
        end
        r_qhead.id   <= s_axis_tdata[255:224];
        r_qhead.hit  <= 1'b0;
        r_qhead.slot <= '0;
        if (r_state == sqbs_pkg::S_SEARCH && chain[sqbs_pkg::NCELL].valid) begin
            r_hit   <= chain[sqbs_pkg::NCELL].hit;
            r_hslot <= chain[sqbs_pkg::NCELL].slot;
        end
        if (r_state == sqbs_pkg::S_DECIDE) begin
            if (r_mode != sqbs_pkg::MODE_TEX) begin
                r_slot <= '0;
                r_new  <= 1'b0;
            end else if (full) begin
                r_slot <= sqbs_pkg::SLOT_W'(1);
                r_new  <= 1'b1;
            end else if (r_hit) begin
                r_slot <= r_hslot;
                r_new  <= 1'b0;
            end else if (r_used >= sqbs_pkg::USED_W'(sqbs_pkg::TEXTURE_SLOTS)) begin
                r_slot <= sqbs_pkg::SLOT_W'(1);
                r_new  <= 1'b1;
            end else begin
                r_slot <= r_used[sqbs_pkg::SLOT_W-1:0];
                r_new  <= 1'b1;
            end
        end
        if (out_ld) begin
            r_mdata <= n_mdata;
            r_muser <= n_muser;
            r_mlast <= n_mlast;
        end
    end

    // Row of slot cells; the cell at index i holds the texture bound to slot i + 1.
    assign chain[0] = r_qhead;

    for (genvar i = 0; i < sqbs_pkg::NCELL; i++) begin : g_cell
        sqbs_slot_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (sqbs_pkg::SLOT_W'(i + 1)),
            .i_used  (r_used),
            .i_q     (chain[i]),
            .i_wr    (wr),
            .o_q     (chain[i+1])
        );
    end

    sqbs_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (math_start),
        .i_angle (r_angle),
        .i_w     (r_w),
        .i_h     (r_h),
        .o_done  (math_done),
        .o_wc    (wc),
        .o_hs    (hs),
        .o_ws    (ws),
        .o_hc    (hc)
    );

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_muser;
    assign m_axis_tlast  = r_mlast;

endmodule
`default_nettype wire

// File: rtl/core/sqbs_slot_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module sqbs_slot_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [sqbs_pkg::SLOT_W-1:0]   i_index,
    input  wire logic [sqbs_pkg::USED_W-1:0]   i_used,
    input  wire sqbs_pkg::t_query              i_q,
    input  wire sqbs_pkg::t_write              i_wr,
    output sqbs_pkg::t_query                   o_q
);

    logic [31:0]      r_id;
    sqbs_pkg::t_query r_q;
    sqbs_pkg::t_query n_q;
    logic             match;

    // An entry counts only while it is bound in the current batch.
    assign match = ({1'b0, i_index} < i_used) && (r_id == i_q.id);

    always_comb begin
        n_q = i_q;
        if (!i_q.hit && match) begin
            n_q.hit  = 1'b1;
            n_q.slot = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else begin
            r_q.valid <= n_q.valid;
        end
        r_q.id   <= n_q.id;
        r_q.hit  <= n_q.hit;
        r_q.slot <= n_q.slot;
        if (i_wr.en && i_wr.slot == i_index) begin
            r_id <= i_wr.id;
        end
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

// File: rtl/core/sqbs_xform.sv
`timescale 1ns / 1ps
`default_nettype none
module sqbs_xform (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [15:0]                         i_angle,
    input  wire logic signed [31:0]                  i_w,
    input  wire logic signed [31:0]                  i_h,
    output logic                                     o_done,
    output logic signed [sqbs_pkg::PROD_W-1:0]       o_wc,
    output logic signed [sqbs_pkg::PROD_W-1:0]       o_hs,
    output logic signed [sqbs_pkg::PROD_W-1:0]       o_ws,
    output logic signed [sqbs_pkg::PROD_W-1:0]       o_hc
);

    localparam logic [3:0] LAST_OP = 4'd11;

    logic                                r_busy;
    logic                                r_ph;
    logic [3:0]                          r_op;
    logic                                r_done;
    logic signed [sqbs_pkg::PROD_W-1:0]  r_p;
    logic [17:0]                         r_z2;
    logic [17:0]                         r_t;
    logic signed [17:0]                  r_sin;
    logic signed [17:0]                  r_cos;
    logic signed [sqbs_pkg::PROD_W-1:0]  r_wc, r_hs, r_ws, r_hc;

    logic [15:0]        ang;
    logic [1:0]         quad;
    logic [14:0]        z;
    logic signed [31:0] opa;
    logic signed [17:0] opb;
    logic [17:0]        ps;
    logic signed [17:0] s_val;

    // Pass 0 evaluates sine, pass 1 cosine as a quarter-turn advanced sine.
    assign ang  = r_op[2] ? (i_angle + sqbs_pkg::Q14_ONE) : i_angle;
    assign quad = ang[15:14];
    assign z    = quad[0] ? (15'(sqbs_pkg::Q14_ONE) - {1'b0, ang[13:0]})
                          : {1'b0, ang[13:0]};
    assign ps   = r_p[31:14];
    assign s_val = quad[1] ? -$signed(ps) : $signed(ps);

    always_comb begin
        opa = '0;
        opb = '0;
        case (r_op)
            4'd0, 4'd4: begin
                opa = $signed({17'd0, z});
                opb = $signed({3'd0, z});
            end
            4'd1, 4'd5: begin
                opa = $signed({14'd0, sqbs_pkg::SIN_C});
                opb = $signed(r_z2);
            end
            4'd2, 4'd6: begin
                opa = $signed({14'd0, r_t});
                opb = $signed(r_z2);
            end
            4'd3, 4'd7: begin
                opa = $signed({14'd0, r_t});
                opb = $signed({3'd0, z});
            end
            4'd8: begin
                opa = i_w;
                opb = r_cos;
            end
            4'd9: begin
                opa = i_h;
                opb = r_sin;
            end
            4'd10: begin
                opa = i_w;
                opb = r_sin;
            end
            4'd11: begin
                opa = i_h;
                opb = r_cos;
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= 1'b0;
            r_op   <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_ph   <= 1'b0;
                r_op   <= '0;
            end else if (r_busy) begin
                r_ph <= ~r_ph;
                if (r_ph) begin
                    if (r_op == LAST_OP) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_op <= r_op + 4'd1;
                    end
                end
            end
        end
        if (r_busy && !r_ph) begin
            r_p <= opa * opb;
        end
        if (r_busy && r_ph) begin
            case (r_op)
                4'd0, 4'd4: r_z2 <= ps;
                4'd1, 4'd5: r_t  <= sqbs_pkg::SIN_B - ps;
                4'd2, 4'd6: r_t  <= sqbs_pkg::SIN_A - ps;
                4'd3:       r_sin <= s_val;
                4'd7:       r_cos <= s_val;
                4'd8:       r_wc <= r_p;
                4'd9:       r_hs <= r_p;
                4'd10:      r_ws <= r_p;
                4'd11:      r_hc <= r_p;
                default:    r_t  <= r_t;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_wc   = r_wc;
    assign o_hs   = r_hs;
    assign o_ws   = r_ws;
    assign o_hc   = r_hc;

endmodule
`default_nettype wire

// File: dv/sprite_quad_batch_setup_top_tb.sv
`timescale 1ns / 1ps
module sprite_quad_batch_setup_top_tb;
    import sqbs_pkg::*;

    localparam longint CYCLE_LIMIT = 400_000;

    // One sprite request as it travels on the slave side.
    typedef struct {
        logic [1:0]  mode;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] size_w;
        logic [31:0] size_h;
        logic [15:0] angle;
        logic [31:0] color;
        logic [15:0] tiling;
        logic [31:0] texture_id;
    } t_sprite_req;

    // One output record, vertex or flush.
    typedef struct {
        logic        kind;
        logic [31:0] vert_x;
        logic [31:0] vert_y;
        logic [31:0] vert_z;
        logic        tex_u;
        logic        tex_v;
        logic [4:0]  slot;
        logic [31:0] vert_color;
        logic [15:0] vert_tiling;
        logic [14:0] batch_quads;
        logic [5:0]  slots_used;
        logic        last;
    } t_vert_rec;

    // Directed row: a request, and for flush rows the counts read off by hand.
    typedef struct {
        t_sprite_req req;
        bit          typed;
        logic [14:0] flush_quads;
        logic [5:0]  flush_slots;
    } t_dir_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [175:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    sprite_quad_batch_setup_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 12 ns clock period.
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Shadow of the batch state kept by the predictor.
    int unsigned quads_in_batch;
    int unsigned bound_slots;
    logic [31:0] bound_ids [32];

    t_vert_rec   pending_verts [$];
    int          fail_count;
    longint      cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // Q1.14 sine of a 65536-per-turn angle, polynomial per quadrant.
    function automatic longint sine_q14(logic [15:0] ang);
        longint z;
        longint z2;
        longint t;
        z = ang[14] ? (16384 - longint'(ang[13:0])) : longint'(ang[13:0]);
        z2 = (z * z) >>> 14;
        t = (1160 * z2) >>> 14;
        t = 10512 - t;
        t = (t * z2) >>> 14;
        t = 25736 - t;
        t = (t * z) >>> 14;
        return ang[15] ? -t : t;
    endfunction

    function automatic t_vert_rec flush_rec(bit last);
        t_vert_rec r;
        r = '{default: '0};
        r.kind = KIND_FLUSH;
        r.batch_quads = quads_in_batch[14:0];
        r.slots_used = bound_slots[5:0];
        r.last = last;
        quads_in_batch = 0;
        bound_slots = 1;
        return r;
    endfunction

    // Works out every record that one accepted request causes.
    task automatic predict_vertices(t_sprite_req q);
        int          sgx [4] = '{-1, 1, 1, -1};
        int          sgy [4] = '{-1, -1, 1, 1};
        logic [4:0]  slot;
        longint      px, py, w, h, sn, cs, cx, cy, rx, ry;
        t_vert_rec   r;
        slot = '0;
        if (q.mode == MODE_NONE) return;
        if (q.mode == MODE_FLUSH) begin
            pending_verts.push_back(flush_rec(1'b1));
            return;
        end
        if (quads_in_batch >= MAX_QUADS) pending_verts.push_back(flush_rec(1'b0));
        if (q.mode == MODE_TEX) begin
            for (int i = 1; i < bound_slots; i++) begin
                if (bound_ids[i] == q.texture_id) begin
                    slot = 5'(i);
                    break;
                end
            end
            if (slot == 0) begin
                if (bound_slots >= TEXTURE_SLOTS) pending_verts.push_back(flush_rec(1'b0));
                slot = bound_slots[4:0];
                bound_ids[slot] = q.texture_id;
                bound_slots++;
            end
        end
        px = longint'(signed'(q.pos_x));
        py = longint'(signed'(q.pos_y));
        w = longint'(signed'(q.size_w));
        h = longint'(signed'(q.size_h));
        sn = sine_q14(q.angle);
        cs = sine_q14(q.angle + 16'd16384);
        for (int k = 0; k < 4; k++) begin
            cx = sgx[k] * w;
            cy = sgy[k] * h;
            // Arithmetic shift gives the floor for negative sums.
            rx = (cx * cs - cy * sn + 16384) >>> 15;
            ry = (cx * sn + cy * cs + 16384) >>> 15;
            r = '{default: '0};
            r.kind = KIND_VERT;
            r.vert_x = 32'(px + rx);
            r.vert_y = 32'(py + ry);
            r.vert_z = q.pos_z;
            r.tex_u = (k == 1 || k == 2);
            r.tex_v = (k >= 2);
            r.slot = slot;
            r.vert_color = q.color;
            r.vert_tiling = (q.mode == MODE_TEX) ? q.tiling : TILE_ONE;
            r.last = (k == 3);
            pending_verts.push_back(r);
        end
        quads_in_batch++;
    endtask

    // Drives one request at the falling edge and holds it until the block
    // takes it; a random idle gap may come first.
    task automatic send_request(t_sprite_req q);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(99) < send_idle_pct) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                break;
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= q.mode;
        s_axis_tdata <= {q.texture_id, q.tiling, q.color, q.angle, q.size_h,
                         q.size_w, q.pos_z, q.pos_y, q.pos_x};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_vertices(q);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($urandom_range(2 * 65536 * 64)) - 32'd65536 * 64;
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return 32'($urandom_range(1 << 24));
        endcase
    endfunction

    function automatic t_sprite_req rand_request(int unsigned tex_pool);
        t_sprite_req q;
        int unsigned pick;
        pick = $urandom_range(99);
        q.mode = (pick < 50) ? MODE_TEX : (pick < 93) ? MODE_SOLID :
                 (pick < 98) ? MODE_FLUSH : MODE_NONE;
        q.pos_x = rand_coord();
        q.pos_y = rand_coord();
        q.pos_z = $urandom;
        q.size_w = rand_coord();
        q.size_h = rand_coord();
        q.angle = ($urandom_range(4) == 0) ? 16'($urandom_range(3)) << 14 : 16'($urandom);
        q.color = $urandom;
        q.tiling = 16'($urandom);
        q.texture_id = ($urandom_range(9) < 8) ? 32'($urandom_range(tex_pool)) : $urandom;
        return q;
    endfunction

    // Output side: random stall driven at the falling edge.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every accepted output transaction is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_vert_rec e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_verts.size() == 0) begin
                $error("unexpected output transaction, tdata %h", m_axis_tdata);
                fail_count++;
            end else begin
                e = pending_verts.pop_front();
                if (m_axis_tuser !== e.kind) begin
                    $error("kind: expected %0d, got %0d", e.kind, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[31:0] !== e.vert_x) begin
                    $error("vert_x: expected %h, got %h", e.vert_x, m_axis_tdata[31:0]);
                    fail_count++;
                end
                if (m_axis_tdata[63:32] !== e.vert_y) begin
                    $error("vert_y: expected %h, got %h", e.vert_y, m_axis_tdata[63:32]);
                    fail_count++;
                end
                if (m_axis_tdata[95:64] !== e.vert_z) begin
                    $error("vert_z: expected %h, got %h", e.vert_z, m_axis_tdata[95:64]);
                    fail_count++;
                end
                if (m_axis_tdata[96] !== e.tex_u) begin
                    $error("tex_u: expected %0d, got %0d", e.tex_u, m_axis_tdata[96]);
                    fail_count++;
                end
                if (m_axis_tdata[97] !== e.tex_v) begin
                    $error("tex_v: expected %0d, got %0d", e.tex_v, m_axis_tdata[97]);
                    fail_count++;
                end
                if (m_axis_tdata[102:98] !== e.slot) begin
                    $error("slot: expected %0d, got %0d", e.slot, m_axis_tdata[102:98]);
                    fail_count++;
                end
                if (m_axis_tdata[134:103] !== e.vert_color) begin
                    $error("vert_color: expected %h, got %h", e.vert_color,
                           m_axis_tdata[134:103]);
                    fail_count++;
                end
                if (m_axis_tdata[150:135] !== e.vert_tiling) begin
                    $error("vert_tiling: expected %h, got %h", e.vert_tiling,
                           m_axis_tdata[150:135]);
                    fail_count++;
                end
                if (m_axis_tdata[165:151] !== e.batch_quads) begin
                    $error("batch_quads: expected %0d, got %0d", e.batch_quads,
                           m_axis_tdata[165:151]);
                    fail_count++;
                end
                if (m_axis_tdata[171:166] !== e.slots_used) begin
                    $error("slots_used: expected %0d, got %0d", e.slots_used,
                           m_axis_tdata[171:166]);
                    fail_count++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_dir_row    rows [$];
        t_dir_row    row;
        t_sprite_req q;
        t_vert_rec   typed_rec;
        int unsigned idle_send [4] = '{0, 88, 0, 26};
        int unsigned idle_recv [4] = '{0, 0, 88, 26};

        fail_count = 0;
        cycle_count = 0;
        quads_in_batch = 0;
        bound_slots = 1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = MODE_SOLID;
        m_axis_tready = 1'b0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows. Flush rows carry their counts typed in by hand.
        row = '{default: '0};
        row.req.mode = MODE_FLUSH; row.typed = 1; row.flush_quads = 0; row.flush_slots = 1;
        rows.push_back(row);
        row = '{default: '0};
        row.req.mode = MODE_SOLID;
        rows.push_back(row);
        row.req.size_w = 32'h0001_0000; row.req.size_h = 32'h0002_0000;
        row.req.color = 32'h1122_3344;
        rows.push_back(row);
        row.req.angle = 16'd16384;
        rows.push_back(row);
        row.req.angle = 16'd32768; row.req.pos_x = 32'h7FFF_FFFF; row.req.pos_y = 32'h7FFF_FFFF;
        row.req.pos_z = 32'h7FFF_FFFF; row.req.size_w = 32'h7FFF_FFFF;
        row.req.size_h = 32'h7FFF_FFFF;
        rows.push_back(row);
        row.req.angle = 16'hFFFF; row.req.pos_x = 32'h8000_0000; row.req.pos_y = 32'h8000_0000;
        row.req.pos_z = 32'h8000_0000; row.req.size_w = 32'h8000_0000;
        row.req.size_h = 32'h8000_0000; row.req.color = 32'hFFFF_FFFF;
        row.req.tiling = 16'hFFFF; row.req.texture_id = 32'hFFFF_FFFF;
        rows.push_back(row);
        row = '{default: '0};
        row.req.mode = MODE_TEX; row.req.size_w = 32'h0004_0000; row.req.size_h = 32'h0004_0000;
        row.req.texture_id = 32'd5; row.req.tiling = 16'h0100; row.req.angle = 16'd8192;
        rows.push_back(row);
        row.req.tiling = 16'hFFFF; row.req.angle = 16'd49152;
        rows.push_back(row);
        row.req.texture_id = 32'hFFFF_FFFF; row.req.tiling = 16'h0000;
        rows.push_back(row);
        row.req.texture_id = 32'd0;
        rows.push_back(row);
        row.req.texture_id = 32'd5; row.req.color = 32'hA5A5_5A5A;
        rows.push_back(row);
        // Unused mode with every data bit set must be ignored.
        row.req = '{mode: MODE_NONE, default: '1};
        rows.push_back(row);
        row = '{default: '0};
        row.req.mode = MODE_FLUSH; row.typed = 1; row.flush_quads = 10; row.flush_slots = 4;
        rows.push_back(row);
        row.flush_quads = 0; row.flush_slots = 1;
        rows.push_back(row);

        foreach (rows[i]) begin
            send_request(rows[i].req);
            if (rows[i].typed) begin
                void'(pending_verts.pop_back());
                typed_rec = '{default: '0};
                typed_rec.kind = KIND_FLUSH;
                typed_rec.batch_quads = rows[i].flush_quads;
                typed_rec.slots_used = rows[i].flush_slots;
                typed_rec.last = 1'b1;
                pending_verts.push_back(typed_rec);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_send[ph];
            recv_stall_pct = idle_recv[ph];
            // A run of distinct textures overflows the slot table.
            if (ph == 1 || ph == 3) begin
                for (int n = 0; n < 34; n++) begin
                    q = rand_request(40);
                    q.mode = MODE_TEX;
                    q.texture_id = 32'h1000_0000 + n + ph * 64;
                    send_request(q);
                end
            end
            for (int n = 0; n < 70; n++) begin
                send_request(rand_request((ph < 2) ? 40 : 8));
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_verts.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
